FILE: src/packed_hsl_to_rgba_top_assert.svh
// Assertion macros for the packed HSL to RGBA converter.
// Included by the converter's top level; needs no other file.
`ifndef PACKED_HSL_TO_RGBA_TOP_ASSERT_SVH
`define PACKED_HSL_TO_RGBA_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked only outside reset.
`define PHR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define PHR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PHR_ASSERT(label, clk, rst, prop, msg)
`define PHR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: src/phr_pkg.sv
// Types, constants and decode functions for the packed HSL to RGBA converter.
// Stands alone; used by packed_hsl_to_rgba_top.
`default_nettype none

package phr_pkg;

  localparam int OUT_BITS_DEFAULT = 8;

  // Q16 values up to and including 1.0 need 17 bits.
  localparam int Q_W = 17;
  localparam int D_W = 18;
  localparam int F_W = 18;
  localparam int M_W = 20;

  localparam logic [Q_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [15:0]    HALF_Q16  = 16'd32768;
  localparam logic [Q_W-1:0] THIRD_Q16 = 17'd21845;

  // 65536 = 127 * 516 + 4 and 65536 = 7 * 9362 + 2.
  localparam logic [Q_W-1:0] LIT_STEP = 17'd516;
  localparam logic [Q_W-1:0] SAT_STEP = 17'd9362;

  // ceil(2^32 / 255); exact floor division by 255 for operands below 2^24.
  localparam logic [24:0] RECIP_255 = 25'd16843010;

  typedef enum logic [1:0] {
    PC_RISE,
    PC_HIGH,
    PC_FALL,
    PC_LOW
  } piece_t;

  typedef struct packed {
    piece_t         piece;
    logic [F_W-1:0] slope;
  } chan_sel_t;

  // Lightness / 127 in Q16, rounded half up.
  function automatic logic [Q_W-1:0] lit_to_q16(input logic [6:0] lit);
    logic [Q_W-1:0] base;
    base = Q_W'(lit) * LIT_STEP;
    return base + Q_W'(lit >= 7'd16) + Q_W'(lit >= 7'd48)
         + Q_W'(lit >= 7'd80) + Q_W'(lit >= 7'd112);
  endfunction

  // Saturation / 7 in Q16, rounded half up.
  function automatic logic [Q_W-1:0] sat_to_q16(input logic [2:0] sat);
    logic [Q_W-1:0] base;
    base = Q_W'(sat) * SAT_STEP;
    return base + Q_W'(sat >= 3'd2) + Q_W'(sat >= 3'd6);
  endfunction

  // Picks the segment of the hue ramp and the slope factor that goes with it.
  function automatic chan_sel_t hue_piece(input logic [Q_W-1:0] t);
    logic [18:0] t6;
    logic [18:0] t3;
    chan_sel_t   sel;
    t6 = 19'(t) * 19'd6;
    t3 = 19'(t) * 19'd3;
    if (t6 < 19'd65536) begin
      sel.piece = PC_RISE;
      sel.slope = F_W'(t6);
    end else if (t < 17'd32768) begin
      sel.piece = PC_HIGH;
      sel.slope = '0;
    end else if (t3 < 19'd131072) begin
      sel.piece = PC_FALL;
      sel.slope = F_W'(19'd262144 - t6);
    end else begin
      sel.piece = PC_LOW;
      sel.slope = '0;
    end
    return sel;
  endfunction

endpackage

`default_nettype wire

FILE: src/packed_hsl_to_rgba_top.sv
// Packed HSL to RGBA converter: six-stage pipeline with stream ports.
// Depends on phr_pkg and packed_hsl_to_rgba_top_assert.svh.
`default_nettype none

`include "packed_hsl_to_rgba_top_assert.svh"

// Takes one packed 6/3/7 HSL color and a transparency byte per item and returns
// rounded, clamped red, green, blue and opacity of OUT_BITS bits each. One item
// enters every cycle while the output is not stalled; a result leaves once it has
// passed all six register stages: operand decode, the L*S product and ramp selection,
// the q/p arithmetic and ramp height, the slope product, the output scaling product and
// the final rounding. Each stage holds its item until the next one is free, so bubbles
// close up under a stalled output and input is taken while any stage is empty.
module packed_hsl_to_rgba_top
  import phr_pkg::*;
#(
  parameter int OUT_BITS = OUT_BITS_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // packed_color [15:0], transparency [23:16]
  input  wire logic [23:0]                         s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // red, green, blue, opacity, OUT_BITS each from the lowest bit up, zero padded
  output logic [((4*OUT_BITS+7)/8)*8-1:0]          m_axis_tdata
);

  localparam int OUT_W = ((4*OUT_BITS+7)/8)*8;
  localparam int NS    = 6;
  localparam int N_W   = 8 + OUT_BITS;
  localparam int R_W   = N_W + 25;
  localparam int P_W   = Q_W + OUT_BITS;
  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  // Stage 1: decoded operands.
  logic [Q_W-1:0]      lq1, sq1;
  logic                grey1;
  logic [Q_W-1:0]      t1 [3];
  logic [N_W-1:0]      opn1;
  // Stage 2: L*S and ramp selection.
  logic [Q_W-1:0]      lq2, sq2, ls2;
  logic                grey2;
  chan_sel_t           sel2 [3];
  logic [OUT_BITS-1:0] op2;
  // Stage 3: q, p and the ramp height.
  logic [Q_W-1:0]      lq3;
  logic                grey3;
  logic [D_W-1:0]      q3, p3, d3;
  chan_sel_t           sel3 [3];
  logic [OUT_BITS-1:0] op3;
  // Stage 4: slope products.
  logic [Q_W-1:0]      lq4;
  logic                grey4;
  logic [D_W-1:0]      q4, p4;
  logic [M_W-1:0]      m4 [3];
  piece_t              pc4 [3];
  logic [OUT_BITS-1:0] op4;
  // Stage 5: channels scaled to the output range.
  logic [P_W-1:0]      prod5 [3];
  logic [OUT_BITS-1:0] op5;
  // Stage 6: output register.
  logic [OUT_BITS-1:0] chan6 [3];
  logic [OUT_BITS-1:0] op6;

  // Stage 1 logic.
  logic [15:0]    col;
  logic [7:0]     tr;
  logic [Q_W-1:0] h_full;
  logic [Q_W-1:0] t_red;
  logic [Q_W-1:0] t_red_raw;
  logic [Q_W-1:0] t_blue;

  // Later stage logic.
  logic [33:0]    ls_prod;
  logic [R_W-1:0] op_prod;
  logic [D_W-1:0] q_c, p_c, two_l;
  logic [35:0]    m_prod [3];
  logic [M_W:0]   v_wide [3];
  logic [Q_W-1:0] v_clamp [3];
  logic [P_W-1:0] v_round [3];
  logic [OUT_BITS:0] v_top [3];

  // A stage takes a new item when it is empty or its item moves on.
  always_comb begin
    en[NS-1] = !vld[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld[NS-1];
  assign m_axis_tdata  = OUT_W'({op6, chan6[2], chan6[1], chan6[0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  always_comb begin
    col       = s_axis_tdata[15:0];
    tr        = s_axis_tdata[23:16];
    h_full    = {1'b0, col[15:10], 10'b0};
    t_red_raw = h_full + THIRD_Q16;
    t_red     = (t_red_raw > ONE_Q16) ? (t_red_raw - ONE_Q16) : t_red_raw;
    t_blue    = (h_full < THIRD_Q16) ? (h_full + ONE_Q16 - THIRD_Q16)
                                     : (h_full - THIRD_Q16);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lq1   <= lit_to_q16(col[6:0]);
      sq1   <= sat_to_q16(col[9:7]);
      grey1 <= (col[9:7] == 3'd0);
      t1[0] <= t_red;
      t1[1] <= h_full;
      t1[2] <= t_blue;
      opn1  <= N_W'(8'd255 - tr) * N_W'(OUT_MAX) + N_W'(127);
    end
  end

  always_comb begin
    ls_prod = 34'(lq1) * 34'(sq1) + 34'(HALF_Q16);
    op_prod = R_W'(opn1) * R_W'(RECIP_255);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      lq2   <= lq1;
      sq2   <= sq1;
      grey2 <= grey1;
      ls2   <= ls_prod[32:16];
      op2   <= op_prod[32 +: OUT_BITS];
      for (int c = 0; c < 3; c++) begin
        sel2[c] <= hue_piece(t1[c]);
      end
    end
  end

  always_comb begin
    two_l = {lq2, 1'b0};
    if (lq2 < Q_W'(HALF_Q16)) begin
      q_c = D_W'(lq2) + D_W'(ls2);
    end else begin
      q_c = D_W'(lq2) + D_W'(sq2) - D_W'(ls2);
    end
    p_c = (two_l > q_c) ? (two_l - q_c) : '0;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lq3   <= lq2;
      grey3 <= grey2;
      q3    <= q_c;
      p3    <= p_c;
      d3    <= q_c - p_c;
      op3   <= op2;
      for (int c = 0; c < 3; c++) begin
        sel3[c] <= sel2[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      m_prod[c] = 36'(d3) * 36'(sel3[c].slope) + 36'(HALF_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      lq4   <= lq3;
      grey4 <= grey3;
      q4    <= q3;
      p4    <= p3;
      op4   <= op3;
      for (int c = 0; c < 3; c++) begin
        m4[c]  <= m_prod[c][35:16];
        pc4[c] <= sel3[c].piece;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (pc4[c])
        PC_RISE, PC_FALL: v_wide[c] = (M_W+1)'(p4) + (M_W+1)'(m4[c]);
        PC_HIGH:          v_wide[c] = (M_W+1)'(q4);
        default:          v_wide[c] = (M_W+1)'(p4);
      endcase
      if (grey4) begin
        v_wide[c] = (M_W+1)'(lq4);
      end
      v_clamp[c] = (v_wide[c] > (M_W+1)'(ONE_Q16)) ? ONE_Q16 : v_wide[c][Q_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      op5 <= op4;
      for (int c = 0; c < 3; c++) begin
        prod5[c] <= P_W'(v_clamp[c]) * P_W'(OUT_MAX);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v_round[c] = prod5[c] + P_W'(HALF_Q16);
      v_top[c]   = v_round[c][P_W-1:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      op6 <= op5;
      for (int c = 0; c < 3; c++) begin
        chan6[c] <= (v_top[c] > (OUT_BITS+1)'(OUT_MAX)) ? OUT_MAX
                                                         : v_top[c][OUT_BITS-1:0];
      end
    end
  end

  `PHR_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !m_axis_tvalid, "output valid after reset")
  `PHR_ASSERT(a_empty_accepts, clk, rst, !m_axis_tvalid |-> s_axis_tready, "stall with empty output")
  `PHR_ASSERT(a_accept_enters, clk, rst, s_axis_tvalid && s_axis_tready |=> vld[0], "item lost at entry")
  `PHR_ASSERT(a_q_above_p, clk, rst, vld[2] |-> q3 >= p3, "ramp bottom above ramp top")

endmodule

`default_nettype wire

FILE: tb/tb_packed_hsl_to_rgba_top.sv
// Self-checking testbench for the packed HSL to RGBA converter stream block.
// Runs a directed table and random items against its own color predictor.
// Depends on phr_pkg and packed_hsl_to_rgba_top.
module tb_packed_hsl_to_rgba_top;
  timeunit 1ns;
  timeprecision 1ps;

  import phr_pkg::*;

  localparam int OUT_BITS = OUT_BITS_DEFAULT;
  localparam int OUT_W = ((4 * OUT_BITS + 7) / 8) * 8;
  localparam logic [63:0] CHAN_MAX = (64'd1 << OUT_BITS) - 64'd1;
  localparam logic [31:0] Q_ONE = 32'd65536;
  localparam logic [31:0] Q_HALF = 32'd32768;
  localparam logic [31:0] Q_THIRD = 32'd21845;
  localparam int RANDOM_ITEMS = 600;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_ROWS = 32;
  localparam int MAX_PENDING = 1024;

  typedef struct packed {
    logic [OUT_BITS-1:0] red;
    logic [OUT_BITS-1:0] green;
    logic [OUT_BITS-1:0] blue;
    logic [OUT_BITS-1:0] opacity;
  } rgba_t;

  typedef struct {
    logic [15:0] color;
    logic [7:0]  transp;
    bit          typed_in;
    rgba_t       want;
  } color_row_t;

  logic             clk;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  // packed_color [15:0], transparency [23:16]
  logic [23:0]      s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  // red, green, blue, opacity, OUT_BITS each from the lowest bit up, zero padded
  logic [OUT_W-1:0] m_axis_tdata;

  // Expected results in order of acceptance; pend_wr and pend_rd count items.
  rgba_t      pending_rgba[MAX_PENDING];
  int         pend_wr = 0;
  int         pend_rd = 0;
  color_row_t color_rows[MAX_ROWS];
  int         row_count = 0;
  int         mismatches = 0;
  int         stall_cycles = 0;
  int         tx_idle_pct = 30;
  int         rx_idle_pct = 79;
  int         hold_seq = 0;

  packed_hsl_to_rgba_top #(
    .OUT_BITS(OUT_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q16 product, rounded half up.
  function automatic logic [31:0] q16_mul(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] prod;
    prod = 64'(a) * 64'(b) + 64'(Q_HALF);
    return prod[47:16];
  endfunction

  // One channel of the HSL hue ramp at hue position t.
  function automatic logic [31:0] hue_ramp(input logic [31:0] p, input logic [31:0] q,
                                           input logic [31:0] t);
    logic [31:0] d;
    logic [31:0] t6;
    d = q - p;
    t6 = 32'd6 * t;
    if (t6 < Q_ONE) return p + q16_mul(d, t6);
    if (32'd2 * t < Q_ONE) return q;
    if (32'd3 * t < 32'd2 * Q_ONE) return p + q16_mul(d, 32'd4 * Q_ONE - t6);
    return p;
  endfunction

  function automatic logic [OUT_BITS-1:0] to_out_scale(input logic [31:0] v);
    logic [63:0] r;
    if (v > Q_ONE) v = Q_ONE;
    r = (64'(v) * CHAN_MAX + 64'(Q_HALF)) >> 16;
    if (r > CHAN_MAX) r = CHAN_MAX;
    return r[OUT_BITS-1:0];
  endfunction

  function automatic rgba_t hsl_to_rgba(input logic [15:0] color, input logic [7:0] transp);
    logic [31:0] h, s, l, ls, q, p, t_red, t_blue, rv, gv, bv;
    logic [63:0] op;
    rgba_t       res;
    h = 32'(color[15:10]) * 32'd1024;
    s = (32'(color[9:7]) * Q_ONE + 32'd3) / 32'd7;
    l = (32'(color[6:0]) * Q_ONE + 32'd63) / 32'd127;
    rv = l;
    gv = l;
    bv = l;
    if (color[9:7] != 3'd0) begin
      ls = q16_mul(l, s);
      q = (l < Q_HALF) ? (l + ls) : (l + s - ls);
      // Held at zero should rounding ever push 2L below q.
      p = (32'd2 * l > q) ? (32'd2 * l - q) : 32'd0;
      t_red = h + Q_THIRD;
      if (t_red > Q_ONE) t_red = t_red - Q_ONE;
      t_blue = (h < Q_THIRD) ? (h + Q_ONE - Q_THIRD) : (h - Q_THIRD);
      rv = hue_ramp(p, q, t_red);
      gv = hue_ramp(p, q, h);
      bv = hue_ramp(p, q, t_blue);
    end
    op = (64'(8'd255 - transp) * CHAN_MAX * 64'd2 + 64'd255) / 64'd510;
    res.red = to_out_scale(rv);
    res.green = to_out_scale(gv);
    res.blue = to_out_scale(bv);
    res.opacity = op[OUT_BITS-1:0];
    return res;
  endfunction

  task automatic add_row(input logic [15:0] color, input logic [7:0] transp,
                         input bit typed_in, input rgba_t want);
    color_row_t row;
    row.color = color;
    row.transp = transp;
    row.typed_in = typed_in;
    row.want = want;
    color_rows[row_count] = row;
    row_count++;
  endtask

  // Offers one item, waits for its handshake and records the expected color.
  task automatic send_color(input logic [15:0] color, input logic [7:0] transp,
                            input bit typed_in, input rgba_t want);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {transp, color};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end
    pending_rgba[pend_wr] = typed_in ? want : hsl_to_rgba(color, transp);
    pend_wr++;
  endtask

  // Receiver: random back-pressure, plus a long hold-off on request.
  initial begin
    int seen_hold;
    int hold_left;
    seen_hold = 0;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_seq != seen_hold) begin
        seen_hold = hold_seq;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Output check and stall counting; both handshakes are stable at the falling edge.
  initial begin
    rgba_t got;
    rgba_t want;
    forever begin
      @(negedge clk);
      if (!rst && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got.red = m_axis_tdata[0 +: OUT_BITS];
        got.green = m_axis_tdata[OUT_BITS +: OUT_BITS];
        got.blue = m_axis_tdata[2 * OUT_BITS +: OUT_BITS];
        got.opacity = m_axis_tdata[3 * OUT_BITS +: OUT_BITS];
        if (pend_rd == pend_wr) begin
          $error("unexpected result item: %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = pending_rgba[pend_rd];
          pend_rd++;
          if (got.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, got.red);
            mismatches++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, got.green);
            mismatches++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, got.blue);
            mismatches++;
          end
          if (got.opacity !== want.opacity) begin
            $error("opacity: expected %0d, got %0d", want.opacity, got.opacity);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("packed_hsl_to_rgba_top verification failed");
    $finish;
  end

  initial begin
    rgba_t       none;
    logic [15:0] color;
    logic [7:0]  transp;
    int          kind;
    int          sweep[11];
    none = '0;
    sweep = '{0, 10, 11, 21, 22, 31, 32, 42, 43, 53, 63};
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;

    // Black, white and fully clear items can be read off directly.
    add_row(16'h0000, 8'h00, 1'b1, '{'0, '0, '0, CHAN_MAX[OUT_BITS-1:0]});
    add_row(16'h007F, 8'h00, 1'b1, '{CHAN_MAX[OUT_BITS-1:0], CHAN_MAX[OUT_BITS-1:0],
                                     CHAN_MAX[OUT_BITS-1:0], CHAN_MAX[OUT_BITS-1:0]});
    add_row(16'hFFFF, 8'hFF, 1'b1, '{CHAN_MAX[OUT_BITS-1:0], CHAN_MAX[OUT_BITS-1:0],
                                     CHAN_MAX[OUT_BITS-1:0], '0});
    add_row(16'h0000, 8'hFF, 1'b1, '{'0, '0, '0, '0});
    // Zero saturation at mid lightness gives grey whatever the hue.
    add_row({6'd37, 3'd0, 7'd64}, 8'h55, 1'b0, none);
    // Full saturation across the ramp segment boundaries of each channel.
    foreach (sweep[i])
      add_row({6'(sweep[i]), 3'd7, 7'd64}, (i % 2) ? 8'hAA : 8'h55, 1'b0, none);
    for (int sat = 1; sat < 7; sat++)
      add_row({6'd5, 3'(sat), 7'd100}, 8'h0F, 1'b0, none);
    add_row({6'd20, 3'd7, 7'd1}, 8'hF0, 1'b0, none);
    add_row({6'd20, 3'd7, 7'd126}, 8'h01, 1'b0, none);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < row_count; i++)
      send_color(color_rows[i].color, color_rows[i].transp, color_rows[i].typed_in,
                 color_rows[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        tx_idle_pct = 79;
        rx_idle_pct <= 30;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_seq <= hold_seq + 1;
      end
      kind = $urandom_range(9);
      color = 16'($urandom);
      if (kind >= 6 && kind <= 7) begin
        color[9:7] = 3'($urandom_range(1, 7));
      end else if (kind == 8) begin
        case ($urandom_range(3))
          0: color[6:0] = 7'd0;
          1: color[6:0] = 7'd1;
          2: color[6:0] = 7'd126;
          default: color[6:0] = 7'd127;
        endcase
      end else if (kind == 9) begin
        color[9:7] = 3'd7;
        color[6:0] = 7'($urandom_range(62, 65));
      end
      transp = 8'($urandom_range(255));
      send_color(color, transp, 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (pend_rd != pend_wr) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("packed_hsl_to_rgba_top verification clean");
    else
      $display("packed_hsl_to_rgba_top verification failed");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/phr_pkg.sv
src/packed_hsl_to_rgba_top.sv
tb/tb_packed_hsl_to_rgba_top.sv
